// ===== hw/rtl/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, codes and constants for the sensor frame decoder.
// ----------------------------------------------------------------------------
package pfd_pkg;

  // Depth of the op queue between the byte decoder and the frame builder
  localparam int unsigned QUEUE_DEPTH = 4;

  // Varint limits and wire types
  localparam logic [3:0] VARINT_MAX_GROUPS = 4'd10;
  localparam logic [2:0] WT_VARINT         = 3'd0;
  localparam logic [2:0] WT_FIXED32        = 3'd5;
  localparam logic [1:0] FIXED_LAST_BYTE   = 2'd3;

  // Field numbers that the frame knows; zero means "ignore this item"
  localparam logic [3:0] FLD_NONE        = 4'd0;
  localparam logic [3:0] FLD_SEQ         = 4'd1;
  localparam logic [3:0] FLD_TIMESTAMP   = 4'd2;
  localparam logic [3:0] FLD_ROLL        = 4'd3;
  localparam logic [3:0] FLD_PITCH       = 4'd4;
  localparam logic [3:0] FLD_YAW         = 4'd5;
  localparam logic [3:0] FLD_HEART_RATE  = 4'd6;
  localparam logic [3:0] FLD_CONDUCTANCE = 4'd7;
  localparam logic [3:0] FLD_IMU_VALID   = 4'd8;
  localparam logic [3:0] FLD_HR_VALID    = 4'd9;
  localparam logic [3:0] FLD_GSR_VALID   = 4'd10;
  localparam logic [28:0] FLD_MAX        = 29'd10;

  typedef enum logic [1:0] {
    PH_TAG   = 2'd0,
    PH_VALUE = 2'd1,
    PH_FIXED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_WIRE_TYPE = 2'd3
  } status_t;

  // One operation from the decoder to the frame builder
  typedef struct packed {
    logic        commit;   // write value into the field below
    logic [3:0]  field;
    logic [31:0] value;
    logic        nonzero;  // full 64-bit varint was nonzero
    logic        last;     // message ends: emit the frame
    status_t     status;
  } op_t;

  localparam int unsigned OP_W = $bits(op_t);

  // One finished frame
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] timestamp;
    logic [31:0] roll;
    logic [31:0] pitch;
    logic [31:0] yaw;
    logic [31:0] heart_rate;
    logic [31:0] conductance;
    logic        imu_valid;
    logic        hr_valid;
    logic        gsr_valid;
    status_t     status;
  } frame_t;

  // Bits a varint group adds to the low 32 bits of the accumulator
  function automatic logic [31:0] varint_low(input logic [3:0] group, input logic [6:0] d);
    logic [31:0] r;
    case (group)
      4'd0:    r = {25'd0, d};
      4'd1:    r = {18'd0, d, 7'd0};
      4'd2:    r = {11'd0, d, 14'd0};
      4'd3:    r = {4'd0, d, 21'd0};
      4'd4:    r = {d[3:0], 28'd0};
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Whether a varint group sets any bit at or above bit 32 (bit 63 is the top)
  function automatic logic varint_high(input logic [3:0] group, input logic [6:0] d);
    logic r;
    case (group)
      4'd4:                   r = |d[6:4];
      4'd5, 4'd6, 4'd7, 4'd8: r = |d;
      4'd9:                   r = d[0];
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  // Reduce a full tag value to a known field number, or FLD_NONE
  function automatic logic [3:0] classify_field(input logic [31:0] acc, input logic hi);
    logic [3:0] r;
    if (hi || (acc[31:3] > FLD_MAX)) begin
      r = FLD_NONE;
    end else begin
      r = acc[6:3];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pfd_front.sv =====
// ----------------------------------------------------------------------------
// pfd_front
// Byte decoder: walks tags, varints and fixed32 values and emits one op per
// byte that completes a known field or ends the message.
// ----------------------------------------------------------------------------
module pfd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          byte_present,
  input  logic [7:0]    byte_value,
  input  logic          end_of_message,
  output logic          op_valid,
  output pfd_pkg::op_t  op
);

  pfd_pkg::phase_t  phase, phase_next;
  logic [3:0]       group_count, group_count_next;
  logic [31:0]      acc, acc_next;
  logic             acc_hi, acc_hi_next;
  logic [3:0]       field, field_next;
  logic [1:0]       fixed_count, fixed_count_next;
  pfd_pkg::status_t error_code, error_code_next;
  logic [31:0]      acc_byte;
  logic             hi_byte;
  logic             fixed_kind;
  logic             varint_kind;

  // Field kinds that a completed value may land in
  assign fixed_kind  = (field == pfd_pkg::FLD_ROLL) || (field == pfd_pkg::FLD_PITCH) ||
                       (field == pfd_pkg::FLD_YAW) || (field == pfd_pkg::FLD_HEART_RATE) ||
                       (field == pfd_pkg::FLD_CONDUCTANCE);
  assign varint_kind = (field == pfd_pkg::FLD_SEQ) || (field == pfd_pkg::FLD_TIMESTAMP) ||
                       (field == pfd_pkg::FLD_IMU_VALID) || (field == pfd_pkg::FLD_HR_VALID) ||
                       (field == pfd_pkg::FLD_GSR_VALID);

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= pfd_pkg::PH_TAG;
      group_count <= '0;
      acc         <= '0;
      acc_hi      <= 1'b0;
      field       <= pfd_pkg::FLD_NONE;
      fixed_count <= '0;
      error_code  <= pfd_pkg::ST_OK;
    end else begin
      phase       <= phase_next;
      group_count <= group_count_next;
      acc         <= acc_next;
      acc_hi      <= acc_hi_next;
      field       <= field_next;
      fixed_count <= fixed_count_next;
      error_code  <= error_code_next;
    end
  end

  // Decode one byte, then close the message if it ends here
  always_comb begin
    phase_next       = phase;
    group_count_next = group_count;
    acc_next         = acc;
    acc_hi_next      = acc_hi;
    field_next       = field;
    fixed_count_next = fixed_count;
    error_code_next  = error_code;
    op               = '0;
    acc_byte         = '0;
    hi_byte          = 1'b0;

    if (take && byte_present && (error_code == pfd_pkg::ST_OK)) begin
      if (phase == pfd_pkg::PH_FIXED) begin
        acc_byte = acc | ({24'd0, byte_value} << {fixed_count, 3'd0});
        if (fixed_count == pfd_pkg::FIXED_LAST_BYTE) begin
          op.commit        = fixed_kind;
          op.field         = field;
          op.value         = acc_byte;
          acc_next         = '0;
          fixed_count_next = '0;
          phase_next       = pfd_pkg::PH_TAG;
        end else begin
          acc_next         = acc_byte;
          fixed_count_next = fixed_count + 2'd1;
        end
      end else begin
        acc_byte = acc | pfd_pkg::varint_low(group_count, byte_value[6:0]);
        hi_byte  = acc_hi | pfd_pkg::varint_high(group_count, byte_value[6:0]);
        if (byte_value[7]) begin
          acc_next         = acc_byte;
          acc_hi_next      = hi_byte;
          group_count_next = group_count + 4'd1;
          if (group_count_next >= pfd_pkg::VARINT_MAX_GROUPS) begin
            error_code_next = pfd_pkg::ST_TOO_LONG;
          end
        end else begin
          group_count_next = '0;
          acc_next         = '0;
          acc_hi_next      = 1'b0;
          if (phase == pfd_pkg::PH_TAG) begin
            field_next = pfd_pkg::classify_field(acc_byte, hi_byte);
            if (acc_byte[2:0] == pfd_pkg::WT_VARINT) begin
              phase_next = pfd_pkg::PH_VALUE;
            end else if (acc_byte[2:0] == pfd_pkg::WT_FIXED32) begin
              phase_next       = pfd_pkg::PH_FIXED;
              fixed_count_next = '0;
            end else begin
              error_code_next = pfd_pkg::ST_WIRE_TYPE;
            end
          end else begin
            op.commit  = varint_kind;
            op.field   = field;
            op.value   = acc_byte;
            op.nonzero = (acc_byte != 32'd0) || hi_byte;
            phase_next = pfd_pkg::PH_TAG;
          end
        end
      end
    end

    if (take && end_of_message) begin
      op.last = 1'b1;
      if (error_code_next != pfd_pkg::ST_OK) begin
        op.status = error_code_next;
      end else if ((phase_next == pfd_pkg::PH_TAG) && (group_count_next == 4'd0)) begin
        op.status = pfd_pkg::ST_OK;
      end else begin
        op.status = pfd_pkg::ST_TRUNCATED;
      end
      phase_next       = pfd_pkg::PH_TAG;
      group_count_next = '0;
      acc_next         = '0;
      acc_hi_next      = 1'b0;
      field_next       = pfd_pkg::FLD_NONE;
      fixed_count_next = '0;
      error_code_next  = pfd_pkg::ST_OK;
    end
  end

  // Push only ops that change the frame or close it
  assign op_valid = op.commit || op.last;

endmodule

// ===== hw/rtl/pfd_queue.sv =====
// ----------------------------------------------------------------------------
// pfd_queue
// Small register queue of decoder ops between front and back.
// ----------------------------------------------------------------------------
module pfd_queue #(
  parameter int unsigned DEPTH = pfd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  pfd_pkg::op_t  wr_data,
  output logic          full,
  input  logic          rd_en,
  output pfd_pkg::op_t  rd_data,
  output logic          empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

  pfd_pkg::op_t     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Store a pushed op
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/pfd_back.sv =====
// ----------------------------------------------------------------------------
// pfd_back
// Frame builder: applies field writes to the frame registers and moves the
// finished frame into the result register at message end.
// ----------------------------------------------------------------------------
module pfd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_avail,
  input  pfd_pkg::op_t    op,
  output logic            op_take,
  output logic            result_valid,
  output pfd_pkg::frame_t result,
  input  logic            result_take
);

  pfd_pkg::frame_t frame, frame_next;
  pfd_pkg::frame_t updated;
  logic            out_free;

  // Result slot frees up when empty or being popped this cycle
  assign out_free = !result_valid || result_take;
  assign op_take  = op_avail && (!op.last || out_free);

  // Apply the op's field write to the current frame
  always_comb begin
    updated = frame;
    if (op.commit) begin
      case (op.field)
        pfd_pkg::FLD_SEQ:         updated.seq         = op.value;
        pfd_pkg::FLD_TIMESTAMP:   updated.timestamp   = op.value;
        pfd_pkg::FLD_ROLL:        updated.roll        = op.value;
        pfd_pkg::FLD_PITCH:       updated.pitch       = op.value;
        pfd_pkg::FLD_YAW:         updated.yaw         = op.value;
        pfd_pkg::FLD_HEART_RATE:  updated.heart_rate  = op.value;
        pfd_pkg::FLD_CONDUCTANCE: updated.conductance = op.value;
        pfd_pkg::FLD_IMU_VALID:   updated.imu_valid   = op.nonzero;
        pfd_pkg::FLD_HR_VALID:    updated.hr_valid    = op.nonzero;
        pfd_pkg::FLD_GSR_VALID:   updated.gsr_valid   = op.nonzero;
        default:                  updated = frame;
      endcase
    end
    updated.status = op.status;
    frame_next     = frame;
    if (op_take) begin
      frame_next = op.last ? '0 : updated;
    end
  end

  // Hold the frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else begin
      frame <= frame_next;
    end
  end

  // Load the result register at message end, drop it when popped
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (op_take && op.last) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take && op.last) begin
      result <= updated;
    end
  end

endmodule

// ===== hw/rtl/protobuf_sensor_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// protobuf_sensor_frame_decoder
// Decodes a protobuf-encoded sensor frame, one byte per transfer, into a
// single frame result with a status per message.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  input    | push / full       | byte_present, byte_value, end_of_message
//  result   | pop / empty       | seq_number .. gsr_valid, status
//
//  One input transfer per cycle while full is low; each byte is decoded
//  combinationally. The end-of-message transfer writes its op into the op
//  queue, and the frame builder then loads the result register from it.
//  Reset (rst, synchronous) clears decoder state, the queue and the frame.
//  A waiting result stalls the frame builder only at the next end-of-message
//  op; full rises once the op queue of QUEUE_DEPTH entries fills, and the
//  byte decoder then waits.
// ----------------------------------------------------------------------------
module protobuf_sensor_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = pfd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               byte_present,
  input  logic [7:0]         byte_value,
  input  logic               end_of_message,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] seq_number,
  output logic signed [31:0] timestamp_ms,
  output logic [31:0]        roll_bits,
  output logic [31:0]        pitch_bits,
  output logic [31:0]        yaw_bits,
  output logic [31:0]        heart_rate_bits,
  output logic [31:0]        conductance_bits,
  output logic               imu_valid,
  output logic               hr_valid,
  output logic               gsr_valid,
  output logic [1:0]         status
);

  logic            take;
  logic            front_valid;
  pfd_pkg::op_t    front_op;
  pfd_pkg::op_t    queue_op;
  logic            queue_empty;
  logic            back_take;
  logic            result_valid;
  pfd_pkg::frame_t result;

  assign take = push && !full;

  pfd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .byte_present   (byte_present),
    .byte_value     (byte_value),
    .end_of_message (end_of_message),
    .op_valid       (front_valid),
    .op             (front_op)
  );

  pfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_op),
    .full    (full),
    .rd_en   (back_take),
    .rd_data (queue_op),
    .empty   (queue_empty)
  );

  pfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_avail     (!queue_empty),
    .op           (queue_op),
    .op_take      (back_take),
    .result_valid (result_valid),
    .result       (result),
    .result_take  (pop)
  );

  // Drive result ports from the result register
  assign empty            = !result_valid;
  assign seq_number       = $signed(result.seq);
  assign timestamp_ms     = $signed(result.timestamp);
  assign roll_bits        = result.roll;
  assign pitch_bits       = result.pitch;
  assign yaw_bits         = result.yaw;
  assign heart_rate_bits  = result.heart_rate;
  assign conductance_bits = result.conductance;
  assign imu_valid        = result.imu_valid;
  assign hr_valid         = result.hr_valid;
  assign gsr_valid        = result.gsr_valid;
  assign status           = result.status;

endmodule

// ===== hw/rtl/pfd_checker.sv =====
// ----------------------------------------------------------------------------
// pfd_checker
// Port-level checks on the sensor frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pfd_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic               byte_present,
  input  logic [7:0]         byte_value,
  input  logic               end_of_message,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [31:0] seq_number,
  input  logic signed [31:0] timestamp_ms,
  input  logic [31:0]        roll_bits,
  input  logic [31:0]        pitch_bits,
  input  logic [31:0]        yaw_bits,
  input  logic [31:0]        heart_rate_bits,
  input  logic [31:0]        conductance_bits,
  input  logic               imu_valid,
  input  logic               hr_valid,
  input  logic               gsr_valid,
  input  logic [1:0]         status
);

  // Reset leaves no result and room for input
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or full still set after reset");

  // A waiting result holds until popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(status) && $stable(seq_number) &&
                       $stable(conductance_bits) && $stable(gsr_valid))
    else $error("stalled result changed");

  // The op queue only fills after an input transfer
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    full && !$past(full) && !$past(rst) |-> $past(push))
    else $error("full rose without an input transfer");

  // A result only leaves through a pop
  a_result_leave: assert property (@(posedge clk) disable iff (rst)
    empty && !$past(empty) && !$past(rst) |-> $past(pop))
    else $error("result dropped without a pop");

endmodule

bind protobuf_sensor_frame_decoder pfd_checker u_pfd_checker (.*);

// ===== tb/tb_protobuf_sensor_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_protobuf_sensor_frame_decoder
// Feeds encoded sensor frames to the decoder one byte per transfer and checks
// every frame it returns against a cycle-free predictor of the decoder. The
// messages are well-formed frames with random content, plus truncated, overlong,
// bad-wire-type, aliased-field and pure-noise messages. Both handshakes idle
// at random.
// ----------------------------------------------------------------------------
module tb_protobuf_sensor_frame_decoder;

  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned SIDE_LINK    = 0;
  localparam int unsigned SIDE_FRAME   = 1;
  localparam logic [2:0]  WT_LEN_DELIM = 3'd2;

  typedef struct packed {
    logic       present;
    logic [7:0] value;
    logic       last;
  } link_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               byte_present = 1'b0;
  logic [7:0]         byte_value = 8'd0;
  logic               end_of_message = 1'b0;
  logic               pop = 1'b0;
  logic               full;
  logic               empty;
  logic signed [31:0] seq_number;
  logic signed [31:0] timestamp_ms;
  logic [31:0]        roll_bits;
  logic [31:0]        pitch_bits;
  logic [31:0]        yaw_bits;
  logic [31:0]        heart_rate_bits;
  logic [31:0]        conductance_bits;
  logic               imu_valid;
  logic               hr_valid;
  logic               gsr_valid;
  logic [1:0]         status;

  protobuf_sensor_frame_decoder DUT (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .byte_present     (byte_present),
    .byte_value       (byte_value),
    .end_of_message   (end_of_message),
    .empty            (empty),
    .pop              (pop),
    .seq_number       (seq_number),
    .timestamp_ms     (timestamp_ms),
    .roll_bits        (roll_bits),
    .pitch_bits       (pitch_bits),
    .yaw_bits         (yaw_bits),
    .heart_rate_bits  (heart_rate_bits),
    .conductance_bits (conductance_bits),
    .imu_valid        (imu_valid),
    .hr_valid         (hr_valid),
    .gsr_valid        (gsr_valid),
    .status           (status)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Frame predictor state
  // --------------------------------------------------------------------------
  pfd_pkg::phase_t  dec_phase;
  logic [3:0]       dec_groups;
  logic [63:0]      dec_acc;
  logic [60:0]      dec_field;
  logic [1:0]       dec_fixed_cnt;
  pfd_pkg::status_t dec_error;
  pfd_pkg::frame_t  dec_frame;
  pfd_pkg::frame_t  frames_due[$];

  link_item_t  link_items_pending[$];
  logic [7:0]  msg_bytes[$];
  int          n_real_items = 0;
  int          n_queued = 0;
  int          n_sent = 0;
  int          mismatches = 0;
  int          link_gap = 0;
  int          frame_wait = 0;
  int          wait_style[2] = '{0, 0};
  int          wait_left[2] = '{0, 0};

  function automatic void clear_decoder();
    dec_phase     = pfd_pkg::PH_TAG;
    dec_groups    = '0;
    dec_acc       = '0;
    dec_field     = '0;
    dec_fixed_cnt = '0;
    dec_error     = pfd_pkg::ST_OK;
    dec_frame     = '0;
  endfunction

  // Only an exact 61-bit match selects a frame field
  function automatic logic [3:0] known_field();
    return (dec_field[60:4] == '0) ? dec_field[3:0] : pfd_pkg::FLD_NONE;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [63:0] part;
    logic [2:0]  wt;
    if (dec_error != pfd_pkg::ST_OK) return;
    // Fixed32 payload: little-endian bytes, commit on the fourth
    if (dec_phase == pfd_pkg::PH_FIXED) begin
      part = {56'd0, b};
      dec_acc = dec_acc | (part << (8 * dec_fixed_cnt));
      if (dec_fixed_cnt == pfd_pkg::FIXED_LAST_BYTE) begin
        case (known_field())
          pfd_pkg::FLD_ROLL:        dec_frame.roll        = dec_acc[31:0];
          pfd_pkg::FLD_PITCH:       dec_frame.pitch       = dec_acc[31:0];
          pfd_pkg::FLD_YAW:         dec_frame.yaw         = dec_acc[31:0];
          pfd_pkg::FLD_HEART_RATE:  dec_frame.heart_rate  = dec_acc[31:0];
          pfd_pkg::FLD_CONDUCTANCE: dec_frame.conductance = dec_acc[31:0];
          default: ;
        endcase
        dec_acc       = '0;
        dec_fixed_cnt = '0;
        dec_phase     = pfd_pkg::PH_TAG;
      end else begin
        dec_fixed_cnt = dec_fixed_cnt + 2'd1;
      end
      return;
    end
    // Varint group, for a tag or for a value
    part = {57'd0, b[6:0]};
    if (dec_groups < pfd_pkg::VARINT_MAX_GROUPS)
      dec_acc = dec_acc | (part << (7 * dec_groups));
    if (b[7]) begin
      dec_groups = dec_groups + 4'd1;
      if (dec_groups >= pfd_pkg::VARINT_MAX_GROUPS) dec_error = pfd_pkg::ST_TOO_LONG;
      return;
    end
    dec_groups = '0;
    if (dec_phase == pfd_pkg::PH_TAG) begin
      wt        = dec_acc[2:0];
      dec_field = dec_acc[63:3];
      dec_acc   = '0;
      if (wt == pfd_pkg::WT_VARINT) begin
        dec_phase = pfd_pkg::PH_VALUE;
      end else if (wt == pfd_pkg::WT_FIXED32) begin
        dec_phase     = pfd_pkg::PH_FIXED;
        dec_fixed_cnt = '0;
      end else begin
        dec_error = pfd_pkg::ST_WIRE_TYPE;
      end
    end else begin
      case (known_field())
        pfd_pkg::FLD_SEQ:       dec_frame.seq       = dec_acc[31:0];
        pfd_pkg::FLD_TIMESTAMP: dec_frame.timestamp = dec_acc[31:0];
        pfd_pkg::FLD_IMU_VALID: dec_frame.imu_valid = |dec_acc;
        pfd_pkg::FLD_HR_VALID:  dec_frame.hr_valid  = |dec_acc;
        pfd_pkg::FLD_GSR_VALID: dec_frame.gsr_valid = |dec_acc;
        default: ;
      endcase
      dec_acc   = '0;
      dec_phase = pfd_pkg::PH_TAG;
    end
  endfunction

  // End of message: snapshot the frame with its status, then start over
  function automatic void close_frame();
    pfd_pkg::frame_t f;
    f        = dec_frame;
    f.status = dec_error;
    if (dec_error == pfd_pkg::ST_OK && !(dec_phase == pfd_pkg::PH_TAG && dec_groups == '0))
      f.status = pfd_pkg::ST_TRUNCATED;
    frames_due.push_back(f);
    clear_decoder();
  endfunction

  // --------------------------------------------------------------------------
  // Message builders
  // --------------------------------------------------------------------------
  function automatic logic [60:0] fnum(input logic [3:0] f);
    return {57'd0, f};
  endfunction

  function automatic int varint_len(input logic [63:0] v);
    int g;
    g = 1;
    while (g < pfd_pkg::VARINT_MAX_GROUPS && (v >> (7 * g)) != 0) g++;
    return g;
  endfunction

  function automatic void put_varint(input logic [63:0] v, input int groups);
    logic [63:0] rest;
    for (int i = 0; i < groups; i++) begin
      rest = v >> (7 * i);
      msg_bytes.push_back({(i < groups - 1) ? 1'b1 : 1'b0, rest[6:0]});
    end
  endfunction

  // Minimal encoding, or now and then padded with empty groups
  function automatic void put_varint_any(input logic [63:0] v, input bit stretch);
    int groups;
    groups = varint_len(v);
    if (stretch && $urandom_range(0, 5) == 0) groups = groups + $urandom_range(1, 3);
    if (groups > pfd_pkg::VARINT_MAX_GROUPS) groups = pfd_pkg::VARINT_MAX_GROUPS;
    put_varint(v, groups);
  endfunction

  function automatic void put_fixed(input logic [31:0] w);
    for (int i = 0; i < 4; i++) msg_bytes.push_back(w[8 * i +: 8]);
  endfunction

  function automatic void put_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      msg_bytes.push_back(b);
    end
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 127));
      3:       return 64'($urandom());
      4:       return {$urandom(), $urandom()};
      default: return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [60:0] pick_varint_field();
    case ($urandom_range(0, 4))
      0:       return fnum(pfd_pkg::FLD_SEQ);
      1:       return fnum(pfd_pkg::FLD_TIMESTAMP);
      2:       return fnum(pfd_pkg::FLD_IMU_VALID);
      3:       return fnum(pfd_pkg::FLD_HR_VALID);
      default: return fnum(pfd_pkg::FLD_GSR_VALID);
    endcase
  endfunction

  // Field numbers the frame does not know, including ones that alias a known
  // field in their low bits
  function automatic logic [60:0] pick_odd_field();
    logic [63:0] r;
    case ($urandom_range(0, 4))
      0: return fnum(pfd_pkg::FLD_NONE);
      1: return fnum(pfd_pkg::FLD_GSR_VALID) + 61'($urandom_range(1, 5));
      2: return 61'($urandom_range(16, 5000));
      3: begin
        r = {$urandom(), $urandom()};
        return r[60:0] >> $urandom_range(0, 60);
      end
      default: return fnum(4'(pfd_pkg::FLD_SEQ + $urandom_range(0, 9))) |
                      (61'd1 << $urandom_range(4, 60));
    endcase
  endfunction

  function automatic void queue_item(input logic present, input logic [7:0] value,
                                     input logic last);
    link_items_pending.push_back('{present: present, value: value, last: last});
    if (present || last) n_real_items++;
  endfunction

  // Turn the built bytes into link items, ending on the last byte or on a
  // separate empty marker
  function automatic void emit_message(input bit marker_end);
    for (int i = 0; i < msg_bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0) queue_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      queue_item(1'b1, msg_bytes[i], !marker_end && i == msg_bytes.size() - 1);
    end
    if (marker_end || msg_bytes.size() == 0)
      queue_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    msg_bytes.delete();
  endfunction

  function automatic void put_random_field();
    int          kind;
    logic [2:0]  wt;
    logic [7:0]  b;
    logic [60:0] fld;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      put_varint_any({pick_varint_field(), pfd_pkg::WT_VARINT}, 1'b1);
      put_varint_any(pick_value(), 1'b1);
    end else if (kind < 65) begin
      put_varint_any({fnum(4'(pfd_pkg::FLD_ROLL + $urandom_range(0, 4))),
                      pfd_pkg::WT_FIXED32}, 1'b1);
      put_fixed($urandom());
    end else if (kind < 78) begin
      fld = pick_odd_field();
      if ($urandom_range(0, 1)) begin
        put_varint_any({fld, pfd_pkg::WT_VARINT}, 1'b1);
        put_varint_any(pick_value(), 1'b1);
      end else begin
        put_varint_any({fld, pfd_pkg::WT_FIXED32}, 1'b1);
        put_fixed($urandom());
      end
    end else if (kind < 86) begin
      // unsupported wire type, with trailing bytes that must be ignored
      do wt = 3'($urandom_range(0, 7));
      while (wt == pfd_pkg::WT_VARINT || wt == pfd_pkg::WT_FIXED32);
      fld = $urandom_range(0, 1) ? pick_varint_field() : pick_odd_field();
      put_varint_any({fld, wt}, 1'b1);
      put_noise($urandom_range(0, 4));
    end else if (kind < 94) begin
      // overlong varint, in a tag or in a value
      if ($urandom_range(0, 1))
        put_varint_any({pick_varint_field(), pfd_pkg::WT_VARINT}, 1'b0);
      repeat (pfd_pkg::VARINT_MAX_GROUPS) begin
        b = 8'($urandom_range(0, 127));
        msg_bytes.push_back(b | 8'h80);
      end
      put_noise($urandom_range(0, 4));
    end else begin
      // longest legal varint
      put_varint_any({pick_varint_field(), pfd_pkg::WT_VARINT}, 1'b0);
      put_varint(pick_value(), pfd_pkg::VARINT_MAX_GROUPS);
    end
  endfunction

  function automatic void build_random_message();
    int cut;
    if ($urandom_range(0, 19) == 0) begin
      put_noise($urandom_range(1, 24));
    end else begin
      repeat ($urandom_range(0, 7)) put_random_field();
      // cut some messages short, possibly mid item
      if ($urandom_range(0, 7) == 0 && msg_bytes.size() > 0) begin
        cut = $urandom_range(0, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end
    emit_message($urandom_range(0, 1));
  endfunction

  // Per-side wait, in stretches of no idling, light idling and heavy idling
  function automatic int draw_wait(input int side);
    if (wait_left[side] == 0) begin
      wait_style[side] = $urandom_range(0, 2);
      wait_left[side]  = $urandom_range(10, 60);
    end
    wait_left[side]--;
    case (wait_style[side])
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0;
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Link driver: present queued items, predict on every transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : link_driver
    link_item_t it;
    if (rst) begin
      push     <= 1'b0;
      link_gap <= 0;
    end else begin
      if (push && !full) begin
        n_sent++;
        if (byte_present) decode_byte(byte_value);
        if (end_of_message) close_frame();
      end
      // hold the item while full, otherwise idle or advance
      if (!(push && full)) begin
        if (link_gap > 0) begin
          push     <= 1'b0;
          link_gap <= link_gap - 1;
        end else if (link_items_pending.size() != 0) begin
          it = link_items_pending.pop_front();
          byte_present   <= it.present;
          byte_value     <= it.value;
          end_of_message <= it.last;
          push           <= 1'b1;
          link_gap       <= draw_wait(SIDE_LINK);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Frame monitor: compare each popped frame with the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void compare(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  function automatic void check_frame();
    pfd_pkg::frame_t want;
    if (frames_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: frame popped with none expected (seq_number %h, status %h)",
                 $realtime, seq_number, status);
      return;
    end
    want = frames_due.pop_front();
    compare("seq_number", want.seq, seq_number);
    compare("timestamp_ms", want.timestamp, timestamp_ms);
    compare("roll_bits", want.roll, roll_bits);
    compare("pitch_bits", want.pitch, pitch_bits);
    compare("yaw_bits", want.yaw, yaw_bits);
    compare("heart_rate_bits", want.heart_rate, heart_rate_bits);
    compare("conductance_bits", want.conductance, conductance_bits);
    compare("imu_valid", 32'(want.imu_valid), 32'(imu_valid));
    compare("hr_valid", 32'(want.hr_valid), 32'(hr_valid));
    compare("gsr_valid", 32'(want.gsr_valid), 32'(gsr_valid));
    compare("status", 32'(want.status), 32'(status));
  endfunction

  always @(posedge clk) begin : frame_monitor
    int w;
    if (rst) begin
      pop        <= 1'b0;
      frame_wait <= 0;
    end else if (pop && !empty) begin
      check_frame();
      w = draw_wait(SIDE_FRAME);
      frame_wait <= w;
      pop        <= (w == 0);
    end else if (frame_wait > 0) begin
      frame_wait <= frame_wait - 1;
      pop        <= (frame_wait == 1);
    end else begin
      pop <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int n_directed;
    clear_decoder();

    // empty message: all defaults
    emit_message(1'b1);
    // unsupported wire type on the only byte
    put_varint_any({fnum(pfd_pkg::FLD_SEQ), WT_LEN_DELIM}, 1'b0);
    emit_message(1'b0);
    // message ends inside a fixed32 value
    put_varint_any({fnum(pfd_pkg::FLD_ROLL), pfd_pkg::WT_FIXED32}, 1'b0);
    msg_bytes.push_back(8'h12);
    emit_message(1'b0);
    // repeated field, last occurrence wins
    put_varint_any({fnum(pfd_pkg::FLD_IMU_VALID), pfd_pkg::WT_VARINT}, 1'b0);
    put_varint_any(64'd1, 1'b0);
    put_varint_any({fnum(pfd_pkg::FLD_IMU_VALID), pfd_pkg::WT_VARINT}, 1'b0);
    put_varint_any(64'd0, 1'b0);
    emit_message(1'b0);
    // largest varint value, ten groups
    put_varint_any({fnum(pfd_pkg::FLD_SEQ), pfd_pkg::WT_VARINT}, 1'b0);
    put_varint_any('1, 1'b0);
    emit_message(1'b0);
    // largest fixed32 value, closed by an empty marker
    put_varint_any({fnum(pfd_pkg::FLD_YAW), pfd_pkg::WT_FIXED32}, 1'b0);
    put_fixed('1);
    emit_message(1'b1);

    n_directed = n_real_items;
    while (n_real_items < n_directed + RANDOM_ITEMS) build_random_message();
    n_queued = link_items_pending.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // drain: all items sent, all frames back, then watch for strays
    while (n_sent < n_queued) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
